// File: rtl/gccs_pkg.sv
// ----------------------------------------------------------------------------
// gccs_pkg
// Shared types and constants of the grid cell contour segment block.
// ----------------------------------------------------------------------------
package gccs_pkg;

   localparam int VAL_W     = 24;   // corner intensity, Q16.8
   localparam int IDX_W     = 10;   // cell row and column
   localparam int POS_W     = 18;   // endpoint position, Q10.8
   localparam int FRAC_W    = 9;    // position along an edge, 0..256
   localparam int LVL_W     = 4;    // level counter, up to sixteen levels
   localparam int LV_W      = 5;    // effective level count
   localparam int PROD_W    = VAL_W + LV_W;
   localparam int REQ_W     = 120;
   localparam int RSP_W     = 80;
   localparam logic [VAL_W-1:0] MIN_DIFF = 24'd51;  // 0.2 in Q16.8

   localparam logic CSR_NUM_LEVELS = 1'b0;
   localparam logic CSR_MAX_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LMUL,
      ST_LTEST,
      ST_DIV,
      ST_SCAN,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic             load;
      logic             setup;
      logic             lmul;
      logic             div_start;
      logic             store;
      logic             rd;
      logic             out_load;
      logic [1:0]       edge_sel;
      logic [1:0]       e2_sel;
      logic [LVL_W-1:0] lvl;
   } cmd_type;

   typedef struct packed {
      logic [LV_W-1:0] lv_eff;
      logic            hit;
      logic            div_done;
      logic            pair_valid;
      logic            out_free;
      logic            last_pair;
      logic            no_pairs;
   } status_type;

endpackage

// File: rtl/grid_cell_contour_segments.sv
// ----------------------------------------------------------------------------
// grid_cell_contour_segments
// Marching-squares contour segments for one grid cell per input transfer.
// ----------------------------------------------------------------------------
// channel  direction  fields (lowest bit up)
// req_     in         tdata: cell_row, cell_col, top_left, top_right,
//                     bottom_left, bottom_right values
// rsp_     out        tdata: level_index, start_col, start_row, end_col,
//                     end_row; tlast: last segment of the cell
// csr_     in         index 0 num_levels, 1 max_height; data
//
// Each cell is tested at every effective level on each of its edges, with the
// serial divider run for each edge crossing; then the candidate pairs are
// scanned and an output load is made for each segment.
// The next cell is taken once the last segment of the cell sits in the
// output register. A stalled rsp_tready holds the walk before each load.
// Reset is synchronous; the crossing store needs no clearing.
module grid_cell_contour_segments #(
   parameter int LEVELS_MAX = 8,
   parameter int GRID_DIM   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // row[9:0] col[19:10] tl[43:20] tr[67:44] bl[91:68] br[115:92]
   input  logic [gccs_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // level[2:0] start_col[20:3] start_row[38:21] end_col[56:39] end_row[74:57]
   output logic [gccs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [gccs_pkg::VAL_W-1:0]    csr_data
);

   gccs_pkg::cmd_type    cmd;
   gccs_pkg::status_type status;

   assign csr_ready = 1'b1;

   gccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gccs_datapath #(
      .LEVELS_MAX (LEVELS_MAX),
      .GRID_DIM   (GRID_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/gccs_div.sv
// ----------------------------------------------------------------------------
// gccs_div
// Restoring divider: floor(numer * 256 / den) for numer <= den, one bit a cycle.
// ----------------------------------------------------------------------------
module gccs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gccs_pkg::PROD_W-1:0]     numer,
   input  logic [gccs_pkg::PROD_W-1:0]     den,
   output logic                            done,
   output logic [gccs_pkg::FRAC_W-1:0]     quot
);

   logic [gccs_pkg::PROD_W:0]   rem_ff, rem_in;
   logic [gccs_pkg::FRAC_W-1:0] q_ff, q_in;
   logic [3:0]                  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [gccs_pkg::PROD_W:0]   r2;
   logic [gccs_pkg::PROD_W:0]   den_x;
   logic                        qb;
   logic                        q8;

   assign den_x = {1'b0, den};
   assign r2    = {rem_ff[gccs_pkg::PROD_W-1:0], 1'b0};
   assign qb    = (r2 >= den_x);
   assign q8    = (numer >= den);

   // first bit on start, then shift and subtract
   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = q8 ? {1'b0, numer - den} : {1'b0, numer};
         q_in    = {{(gccs_pkg::FRAC_W-1){1'b0}}, q8};
         step_in = 4'd8;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qb ? (r2 - den_x) : r2;
         q_in    = {q_ff[gccs_pkg::FRAC_W-2:0], qb};
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: rtl/gccs_datapath.sv
// ----------------------------------------------------------------------------
// gccs_datapath
// Cell registers, level tests, crossing store, pair count and output register.
// ----------------------------------------------------------------------------
module gccs_datapath #(
   parameter int LEVELS_MAX = 8,
   parameter int GRID_DIM   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gccs_pkg::REQ_W-1:0]    req_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_index,
   input  logic [gccs_pkg::VAL_W-1:0]    csr_data,
   input  gccs_pkg::cmd_type             cmd,
   output gccs_pkg::status_type          status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gccs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int TW    = (LEVELS_MAX > 1) ? $clog2(LEVELS_MAX) : 1;
   localparam int TD    = 2 ** TW;
   localparam int DEPTH = 4 * TD;
   localparam int PC_W  = $clog2(6 * LEVELS_MAX + 1);
   localparam int PW    = gccs_pkg::PROD_W;
   localparam int VW    = gccs_pkg::VAL_W;
   localparam int IW    = gccs_pkg::IDX_W;
   localparam int FW    = gccs_pkg::FRAC_W;
   localparam int OW    = gccs_pkg::POS_W;

   // configuration
   logic [3:0]    nl_ff;
   logic [VW-1:0] mh_ff;
   logic [gccs_pkg::LV_W-1:0] lv_eff;
   logic [VW-1:0] mh_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_ff <= 4'd8;
         mh_ff <= {VW{1'b1}};
      end else if (csr_valid) begin
         unique case (csr_index)
            gccs_pkg::CSR_NUM_LEVELS: nl_ff <= csr_data[3:0];
            gccs_pkg::CSR_MAX_HEIGHT: mh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (nl_ff == 4'd0)
         lv_eff = gccs_pkg::LV_W'(1);
      else if ({1'b0, nl_ff} > gccs_pkg::LV_W'(LEVELS_MAX))
         lv_eff = gccs_pkg::LV_W'(LEVELS_MAX);
      else
         lv_eff = {1'b0, nl_ff};
   end
   assign mh_eff = (mh_ff == '0) ? VW'(1) : mh_ff;

   // cell capture with index saturation
   logic [IW-1:0] row_ff, col_ff, row_sat, col_sat;
   logic [VW-1:0] tl_ff, tr_ff, bl_ff, br_ff;

   assign row_sat = (int'(req_tdata[9:0])   > GRID_DIM - 2) ? IW'(GRID_DIM - 2)
                                                            : req_tdata[9:0];
   assign col_sat = (int'(req_tdata[19:10]) > GRID_DIM - 2) ? IW'(GRID_DIM - 2)
                                                            : req_tdata[19:10];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= row_sat;
         col_ff <= col_sat;
         tl_ff  <= req_tdata[43:20];
         tr_ff  <= req_tdata[67:44];
         bl_ff  <= req_tdata[91:68];
         br_ff  <= req_tdata[115:92];
      end
   end

   // edge setup: scaled ends, span and skip test
   logic [VW-1:0] ea, eb, ediff;
   logic [PW-1:0] alv_ff, lo_lv_ff, hi_lv_ff, den_ff, v_ff;
   logic          up_ff, live_ff;
   logic [PW-1:0] alv, blv;
   logic          live;

   always_comb begin
      unique case (cmd.edge_sel)
         2'd0: begin ea = tl_ff; eb = tr_ff; end
         2'd1: begin ea = tl_ff; eb = bl_ff; end
         2'd2: begin ea = bl_ff; eb = br_ff; end
         default: begin ea = tr_ff; eb = br_ff; end
      endcase
   end

   assign ediff = (ea > eb) ? (ea - eb) : (eb - ea);
   assign alv   = PW'(ea) * PW'(lv_eff);
   assign blv   = PW'(eb) * PW'(lv_eff);
   assign live  = !((ea == '0) && (eb == '0)) && !((ea >= mh_eff) && (eb >= mh_eff))
                  && (ediff >= gccs_pkg::MIN_DIFF);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         alv_ff   <= alv;
         lo_lv_ff <= (ea < eb) ? alv : blv;
         hi_lv_ff <= (ea < eb) ? blv : alv;
         den_ff   <= PW'(ediff) * PW'(lv_eff);
         up_ff    <= (eb > ea);
         live_ff  <= live;
      end
      if (cmd.lmul)
         v_ff <= PW'(cmd.lvl) * PW'(mh_eff);
   end

   // level test and divider
   logic [PW-1:0] numer;
   logic          div_done;
   logic [FW-1:0] quot;

   assign numer = up_ff ? (v_ff - alv_ff) : (alv_ff - v_ff);

   gccs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // crossing store and valid bits
   logic [FW-1:0] frac_mem [DEPTH];
   logic [3:0][TD-1:0] valid_ff;
   logic [PC_W-1:0] pairs_ff;
   logic [TW-1:0]   t_idx;
   logic [1:0]      lvl_cnt;

   assign t_idx   = cmd.lvl[TW-1:0];
   assign lvl_cnt = 2'(valid_ff[0][t_idx]) + 2'(valid_ff[1][t_idx])
                  + 2'(valid_ff[2][t_idx]);

   always_ff @(posedge clock) begin
      if (cmd.store)
         frac_mem[{cmd.edge_sel, t_idx}] <= quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pairs_ff <= '0;
      end else if (cmd.load) begin
         valid_ff <= '0;
         pairs_ff <= '0;
      end else if (cmd.store) begin
         valid_ff[cmd.edge_sel][t_idx] <= 1'b1;
         pairs_ff <= pairs_ff + PC_W'(lvl_cnt);
      end else if (cmd.out_load) begin
         pairs_ff <= pairs_ff - PC_W'(1);
      end
   end

   // pair read
   logic [FW-1:0] rd_a_ff, rd_b_ff;
   logic [1:0]    ea_ff, eb_ff;
   logic [2:0]    lt_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_a_ff <= frac_mem[{cmd.edge_sel, t_idx}];
         rd_b_ff <= frac_mem[{cmd.e2_sel, t_idx}];
         ea_ff   <= cmd.edge_sel;
         eb_ff   <= cmd.e2_sel;
         lt_ff   <= cmd.lvl[2:0];
      end
   end

   // endpoint positions from edge and fraction
   function automatic logic [2*OW-1:0] edge_pos(input logic [1:0] e,
                                                input logic [FW-1:0] f,
                                                input logic [IW-1:0] c,
                                                input logic [IW-1:0] r);
      logic [IW:0]   cb;
      logic [IW:0]   rb;
      logic [IW+8:0] cp;
      logic [IW+8:0] rp;
      logic          horiz;
      horiz = (e == 2'd0) || (e == 2'd2);
      cb = {1'b0, c} + (IW+1)'(e == 2'd3);
      rb = {1'b0, r} + (IW+1)'(e == 2'd2);
      cp = {cb, 8'b0} + (IW+9)'(horiz ? f : '0);
      rp = {rb, 8'b0} + (IW+9)'(horiz ? '0 : f);
      return {rp[OW-1:0], cp[OW-1:0]};
   endfunction

   logic [2*OW-1:0] pa, pb;
   assign pa = edge_pos(ea_ff, rd_a_ff, col_ff, row_ff);
   assign pb = edge_pos(eb_ff, rd_b_ff, col_ff, row_ff);

   // output register
   logic                       rsp_valid_ff;
   logic [gccs_pkg::RSP_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         rsp_data_ff <= {5'b0, pb[2*OW-1:OW], pb[OW-1:0], pa[2*OW-1:OW], pa[OW-1:0],
                         lt_ff};
         rsp_last_ff <= (pairs_ff == PC_W'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // status to the controller
   assign status.lv_eff     = lv_eff;
   assign status.hit        = live_ff && (v_ff >= lo_lv_ff) && (v_ff <= hi_lv_ff);
   assign status.div_done   = div_done;
   assign status.pair_valid = valid_ff[cmd.edge_sel][t_idx] && valid_ff[cmd.e2_sel][t_idx];
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.last_pair  = (pairs_ff == PC_W'(1));
   assign status.no_pairs   = (pairs_ff == '0);

endmodule

// File: rtl/gccs_ctrl.sv
// ----------------------------------------------------------------------------
// gccs_ctrl
// Sequencer: walks edges and levels, then walks crossing pairs for output.
// ----------------------------------------------------------------------------
module gccs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  gccs_pkg::status_type  status,
   output gccs_pkg::cmd_type     cmd
);

   gccs_pkg::state_type state_ff, state_in;
   logic [1:0]                 edge_ff, edge_in;
   logic [1:0]                 e2_ff, e2_in;
   logic [gccs_pkg::LVL_W-1:0] lvl_ff, lvl_in;
   logic                       lvl_last;

   assign lvl_last = ({1'b0, lvl_ff} == (status.lv_eff - gccs_pkg::LV_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gccs_pkg::ST_IDLE;
         edge_ff  <= 2'd0;
         e2_ff    <= 2'd1;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
         e2_ff    <= e2_in;
         lvl_ff   <= lvl_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      edge_in       = edge_ff;
      e2_in         = e2_ff;
      lvl_in        = lvl_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.edge_sel  = edge_ff;
      cmd.e2_sel    = e2_ff;
      cmd.lvl       = lvl_ff;

      unique case (state_ff)
         gccs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               edge_in  = 2'd0;
               lvl_in   = '0;
               state_in = gccs_pkg::ST_SETUP;
            end
         end
         gccs_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = gccs_pkg::ST_LMUL;
         end
         gccs_pkg::ST_LMUL: begin
            cmd.lmul = 1'b1;
            state_in = gccs_pkg::ST_LTEST;
         end
         gccs_pkg::ST_LTEST, gccs_pkg::ST_DIV: begin
            if (state_ff == gccs_pkg::ST_LTEST && status.hit) begin
               cmd.div_start = 1'b1;
               state_in      = gccs_pkg::ST_DIV;
            end else if (state_ff == gccs_pkg::ST_LTEST || status.div_done) begin
               cmd.store = (state_ff == gccs_pkg::ST_DIV);
               // advance to the next level, edge, or the pair walk
               if (!lvl_last) begin
                  lvl_in   = lvl_ff + gccs_pkg::LVL_W'(1);
                  state_in = gccs_pkg::ST_LMUL;
               end else if (edge_ff != 2'd3) begin
                  lvl_in   = '0;
                  edge_in  = edge_ff + 2'd1;
                  state_in = gccs_pkg::ST_SETUP;
               end else begin
                  lvl_in   = '0;
                  edge_in  = 2'd0;
                  e2_in    = 2'd1;
                  state_in = gccs_pkg::ST_SCAN;
               end
            end
         end
         gccs_pkg::ST_SCAN, gccs_pkg::ST_LOAD: begin
            priority if (state_ff == gccs_pkg::ST_SCAN && status.no_pairs) begin
               state_in = gccs_pkg::ST_IDLE;
            end else if (state_ff == gccs_pkg::ST_SCAN && status.pair_valid) begin
               cmd.rd   = 1'b1;
               state_in = gccs_pkg::ST_LOAD;
            end else if (state_ff == gccs_pkg::ST_SCAN || status.out_free) begin
               cmd.out_load = (state_ff == gccs_pkg::ST_LOAD);
               if (state_ff == gccs_pkg::ST_LOAD && status.last_pair)
                  state_in = gccs_pkg::ST_IDLE;
               else
                  state_in = gccs_pkg::ST_SCAN;
               // step to the next candidate pair
               if (e2_ff != 2'd3) begin
                  e2_in = e2_ff + 2'd1;
               end else if (!lvl_last) begin
                  lvl_in = lvl_ff + gccs_pkg::LVL_W'(1);
                  e2_in  = edge_ff + 2'd1;
               end else begin
                  lvl_in  = '0;
                  edge_in = edge_ff + 2'd1;
                  e2_in   = edge_ff + 2'd2;
               end
            end else begin
               state_in = state_ff;
            end
         end
         default: state_in = gccs_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: rtl/gccs_checker.sv
// ----------------------------------------------------------------------------
// gccs_checker
// Port-level checks of the contour segment block, bound to the top level.
// ----------------------------------------------------------------------------
module gccs_checker #(
   parameter int LEVELS_MAX = 8
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [gccs_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // go busy after each cell transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("cell accepted back to back");

   // keep the level below the LEVELS_MAX bound
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (LEVELS_MAX >= 8) || (int'(rsp_tdata[2:0]) < LEVELS_MAX))
      else $error("level out of range");

   // pad bits stay clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[79:75] == 5'b0))
      else $error("pad bits set");

endmodule

bind grid_cell_contour_segments gccs_checker #(.LEVELS_MAX(LEVELS_MAX)) u_gccs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid cell contour segment block. Cells are
// streamed in, the expected segments of each cell are computed alongside and
// every segment transfer is compared against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [2:0]                 level;
      logic [gccs_pkg::POS_W-1:0] start_col;
      logic [gccs_pkg::POS_W-1:0] start_row;
      logic [gccs_pkg::POS_W-1:0] end_col;
      logic [gccs_pkg::POS_W-1:0] end_row;
      logic                       last;
   } segment_type;

   typedef struct {
      longint unsigned col;
      longint unsigned row;
      longint unsigned lvl;
   } crossing_type;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [gccs_pkg::REQ_W-1:0]     req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [gccs_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_index;
   logic [gccs_pkg::VAL_W-1:0]     csr_data;

   segment_type expected_segments[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          idling_on;
   bit          sink_stall = 1'b0;
   logic [3:0]  levels_reg;
   logic [gccs_pkg::VAL_W-1:0] height_reg;
   crossing_type crossings[$];

   grid_cell_contour_segments i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Collect the level crossings of one edge, a to b
   task automatic scan_edge(input longint unsigned a, input longint unsigned b,
                            input longint unsigned c0, input longint unsigned r0,
                            input bit horiz, input longint unsigned lv,
                            input longint unsigned mh);
      longint unsigned lo, hi, diff, t1, t2, numer, frac;
      crossing_type cr;
      if (a == 0 && b == 0) return;
      if (a >= mh && b >= mh) return;
      diff = (a > b) ? a - b : b - a;
      if (diff < 51) return;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      t1 = (lo * lv + mh - 1) / mh;
      t2 = (hi * lv) / mh;
      if (t2 > lv - 1) t2 = lv - 1;
      for (longint unsigned t = t1; t <= t2; t++) begin
         if (crossings.size() >= 32) return;
         numer = (b > a) ? t * mh - a * lv : a * lv - t * mh;
         frac = (numer * 256) / (lv * diff);
         cr.col = horiz ? c0 * 256 + frac : c0 * 256;
         cr.row = horiz ? r0 * 256 : r0 * 256 + frac;
         cr.lvl = t;
         crossings.push_back(cr);
      end
   endtask

   // Work out the segments of one cell and queue them
   task automatic predict_segments(input logic [gccs_pkg::REQ_W-1:0] cell_data);
      longint unsigned lv, mh, row, col, tl, tr, bl, br;
      segment_type seg;
      int produced;
      lv = levels_reg;
      mh = height_reg;
      produced = 0;
      if (lv == 0) lv = 1;
      if (lv > 8) lv = 8;
      if (mh == 0) mh = 1;
      row = cell_data[9:0];
      col = cell_data[19:10];
      tl = cell_data[43:20];
      tr = cell_data[67:44];
      bl = cell_data[91:68];
      br = cell_data[115:92];
      if (row > 1022) row = 1022;
      if (col > 1022) col = 1022;
      crossings.delete();
      scan_edge(tl, tr, col, row, 1'b1, lv, mh);
      scan_edge(tl, bl, col, row, 1'b0, lv, mh);
      scan_edge(bl, br, col, row + 1, 1'b1, lv, mh);
      scan_edge(tr, br, col + 1, row, 1'b0, lv, mh);
      for (int k1 = 0; k1 < crossings.size() - 1; k1++) begin
         for (int k2 = k1 + 1; k2 < crossings.size(); k2++) begin
            if (crossings[k1].lvl != crossings[k2].lvl || produced >= 48) continue;
            seg.level = crossings[k1].lvl[2:0];
            seg.start_col = crossings[k1].col[gccs_pkg::POS_W-1:0];
            seg.start_row = crossings[k1].row[gccs_pkg::POS_W-1:0];
            seg.end_col = crossings[k2].col[gccs_pkg::POS_W-1:0];
            seg.end_row = crossings[k2].row[gccs_pkg::POS_W-1:0];
            seg.last = 1'b0;
            expected_segments.push_back(seg);
            produced++;
         end
      end
      if (produced > 0) expected_segments[$].last = 1'b1;
   endtask

   // Hold off for a random burst when idling is on
   task automatic random_gap();
      int n;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 18);
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one cell and predict its segments at the transfer
   task automatic send_cell(input logic [gccs_pkg::REQ_W-1:0] cell_data);
      req_tvalid <= 1'b1;
      req_tdata <= cell_data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_segments(cell_data);
      req_tvalid <= 1'b0;
      @(posedge clock);
      random_gap();
   endtask

   function automatic logic [gccs_pkg::REQ_W-1:0] make_cell(input logic [9:0] row,
         input logic [9:0] col, input logic [23:0] tl, input logic [23:0] tr,
         input logic [23:0] bl, input logic [23:0] br);
      return {4'b0, br, bl, tr, tl, col, row};
   endfunction

   // Random corner value: mix of extremes, small steps and full range
   function automatic logic [23:0] rand_value(input logic [23:0] base);
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return base + 24'($urandom_range(0, 80)) - 24'd40;
         default: return 24'($urandom());
      endcase
   endfunction

   // Wait until every expected segment has arrived, then let the block settle
   task automatic wait_drained();
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [gccs_pkg::VAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == gccs_pkg::CSR_NUM_LEVELS) levels_reg = value[3:0];
      else height_reg = value;
      @(posedge clock);
   endtask

   task automatic test_directed_cells();
      send_cell(make_cell(10'd0, 10'd0, 24'd0, 24'd0, 24'd0, 24'd0));
      send_cell(make_cell(10'd5, 10'd7, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0));
      send_cell(make_cell(10'd1023, 10'd1023, 24'hFFFFFF, 24'd0, 24'd0,
                          24'hFFFFFF));
      send_cell(make_cell(10'd1022, 10'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                          24'hFFFFFF));
      send_cell(make_cell(10'd2, 10'd1022, 24'h800000, 24'h800032, 24'h800033,
                          24'h7FFFCD));
      send_cell(make_cell(10'd512, 10'd256, 24'h100000, 24'hF00000, 24'h700000,
                          24'h300000));
      send_cell(make_cell(10'h2AA, 10'h155, 24'h555555, 24'hAAAAAA, 24'h000001,
                          24'hFFFFFE));
   endtask

   task automatic test_level_settings();
      write_reg(gccs_pkg::CSR_NUM_LEVELS, 24'd1);
      write_reg(gccs_pkg::CSR_MAX_HEIGHT, 24'd1000);
      send_cell(make_cell(10'd3, 10'd4, 24'd0, 24'd2000, 24'd999, 24'd1000));
      send_cell(make_cell(10'd3, 10'd4, 24'd400, 24'd600, 24'd1200, 24'd0));
      wait_drained();
      write_reg(gccs_pkg::CSR_NUM_LEVELS, 24'd0);
      write_reg(gccs_pkg::CSR_MAX_HEIGHT, 24'd0);
      send_cell(make_cell(10'd9, 10'd9, 24'd0, 24'd100, 24'd1, 24'd52));
      wait_drained();
      write_reg(gccs_pkg::CSR_NUM_LEVELS, 24'd15);
      write_reg(gccs_pkg::CSR_MAX_HEIGHT, 24'd255);
      send_cell(make_cell(10'd1, 10'd1, 24'd0, 24'd255, 24'd255, 24'd0));
      send_cell(make_cell(10'd1, 10'd1, 24'd30, 24'd200, 24'd250, 24'd10));
      wait_drained();
      write_reg(gccs_pkg::CSR_NUM_LEVELS, 24'd8);
      write_reg(gccs_pkg::CSR_MAX_HEIGHT, 24'd2048);
      send_cell(make_cell(10'd100, 10'd200, 24'd0, 24'd2047, 24'd2047, 24'd0));
      send_cell(make_cell(10'd100, 10'd200, 24'd256, 24'd1900, 24'd700, 24'd1300));
   endtask

   task automatic test_random_cells(input int count);
      logic [23:0] base;
      logic [9:0] row, col;
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0) begin
            wait_drained();
            write_reg(gccs_pkg::CSR_NUM_LEVELS, 24'($urandom_range(0, 15)));
            write_reg(gccs_pkg::CSR_MAX_HEIGHT, ($urandom_range(0, 3) == 0) ? 24'hFFFFFF
                      : 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 16)));
         end
         if (i >= count - 15) idling_on = 1'b0;
         base = 24'($urandom()) & height_reg;
         row = ($urandom_range(0, 9) == 0) ? 10'h3FF : 10'($urandom());
         col = ($urandom_range(0, 9) == 0) ? 10'h3FF : 10'($urandom());
         send_cell(make_cell(row, col, rand_value(base), rand_value(base),
                             rand_value(base), rand_value(base)));
      end
   endtask

   // Check each segment transfer against the oldest expected one
   always @(posedge clock) begin
      segment_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level = rsp_tdata[2:0];
         got.start_col = rsp_tdata[20:3];
         got.start_row = rsp_tdata[38:21];
         got.end_col = rsp_tdata[56:39];
         got.end_row = rsp_tdata[74:57];
         got.last = rsp_tlast;
         if (expected_segments.size() == 0) begin
            $display("%0t: segment expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_segments.pop_front();
            if (got.level !== want.level)
               $display("%0t: level expected %0d actual %0d", $time, want.level,
                        got.level);
            if (got.start_col !== want.start_col)
               $display("%0t: start_col expected %h actual %h", $time,
                        want.start_col, got.start_col);
            if (got.start_row !== want.start_row)
               $display("%0t: start_row expected %h actual %h", $time,
                        want.start_row, got.start_row);
            if (got.end_col !== want.end_col)
               $display("%0t: end_col expected %h actual %h", $time,
                        want.end_col, got.end_col);
            if (got.end_row !== want.end_row)
               $display("%0t: end_row expected %h actual %h", $time,
                        want.end_row, got.end_row);
            if (got.last !== want.last)
               $display("%0t: last expected %0b actual %0b", $time, want.last,
                        got.last);
            if (got !== want) error_count++;
         end
      end
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
      end else if (idling_on && sink_stall == 1'b0 && $urandom_range(0, 5) == 0) begin
         idle_cycles <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
         sink_stall <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         sink_stall <= 1'b0;
      end
   end

   // Watchdog: end the run when nothing is accepted for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("grid_cell_contour_segments test failed");
            $finish;
         end
      end
   end

   initial begin
      idling_on = 1'b1;
      levels_reg = 4'd8;
      height_reg = 24'hFFFFFF;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= gccs_pkg::CSR_NUM_LEVELS;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cells();
      wait_drained();
      test_level_settings();
      wait_drained();
      test_random_cells(100);
      wait_drained();
      if (error_count == 0) begin
         $display("grid_cell_contour_segments test passed");
      end else begin
         $display("grid_cell_contour_segments test failed");
      end
      $finish;
   end

endmodule
